@@ design/ers_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ers_pkg
// types and constants shared by the emission rate scheduler modules
// ----------------------------------------------------------------------------
package ers_pkg;

  // field widths
  localparam int unsigned TIME_W   = 32;  // time_step, active_duration
  localparam int unsigned RATE_W   = 32;  // emit_rate
  localparam int unsigned CNT_W    = 16;  // live_count, burst_count, max_count, spawn_count
  localparam int unsigned SCALE_W  = 16;  // rate_scale, q8.8
  localparam int unsigned SCALE_SH = 8;
  localparam int unsigned T_W      = 48;  // elapsed time and emission timer
  localparam int unsigned R_W      = RATE_W + SCALE_W - SCALE_SH;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EMIT_RATE       = 3'd0,
    CFG_ACTIVE_DURATION = 3'd1,
    CFG_BURST_COUNT     = 3'd2,
    CFG_ONE_PER_FRAME   = 3'd3,
    CFG_MAX_COUNT       = 3'd4
  } cfg_idx_e;

  localparam logic [CNT_W-1:0] MAX_COUNT_RST = '1;

  // operand set for the shared divider
  typedef enum logic [1:0] {
    DIV_RECIP,  // period = 2^(2f) / rate
    DIV_QUOT,   // request = timer / period
    DIV_MOD     // timer mod period
  } div_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_RECIP,
    ST_RECIP_WAIT,
    ST_QUOT,
    ST_QUOT_WAIT,
    ST_CLAMP,
    ST_MULT,
    ST_TRIM,
    ST_MOD,
    ST_MOD_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic     load_in;
    logic     accum;
    logic     div_start;
    div_sel_e div_sel;
    logic     d_load;
    logic     req_load_direct;
    logic     req_load_div;
    logic     emit_load;
    logic     mul_step;
    logic     timer_clear;
    logic     trim_load;
    logic     mod_load;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic expired;
    logic rate_zero;
    logic req_direct;
    logic div_busy;
    logic commit;
    logic d_zero;
    logic mul_busy;
    logic mod_need;
  } status_t;

endpackage

@@ design/ers_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ers_in_if / ers_out_if
// valid/ready channels for frame ticks and spawn results
// ----------------------------------------------------------------------------
interface ers_in_if;
  logic                         valid;
  logic                         ready;
  logic [ers_pkg::TIME_W-1:0]   time_step;
  logic [ers_pkg::CNT_W-1:0]    live_count;
  logic [ers_pkg::SCALE_W-1:0]  rate_scale;

  modport source (output valid, time_step, live_count, rate_scale, input ready);
  modport sink   (input valid, time_step, live_count, rate_scale, output ready);
endinterface

interface ers_out_if;
  logic                      valid;
  logic                      ready;
  logic [ers_pkg::CNT_W-1:0] spawn_count;
  logic                      expired;

  modport source (output valid, spawn_count, expired, input ready);
  modport sink   (input valid, spawn_count, expired, output ready);
endinterface

@@ design/emission_rate_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emission_rate_scheduler
// per-frame particle spawn count from a saturating emission timer
// ----------------------------------------------------------------------------
// channel   dir  handshake      payload
// in_i      in   valid/ready    time_step[31:0] live_count[15:0] rate_scale[15:0]
// out_o     out  valid/ready    spawn_count[15:0] expired
// cfg       in   cfg_we_i       cfg_idx_i[2:0] cfg_data_i[31:0], no read-back
//
// one tick at a time
// an expired tick goes from ACCUM straight to DONE, skipping the divisions
// a tick that runs the request division steps through RECIP, QUOT and CLAMP
//   and, when it commits, MULT (the shift-add period multiply over the spawn
//   count's significant bits) and TRIM, using the single one-bit-per-cycle divider
// one-per-frame mode without a shortfall adds the timer modulo (MOD, MOD_WAIT)
// reset clears config (max_count to all ones), elapsed time and timer at once
// a waiting result sits in the output register; the next request is taken
//   meanwhile and the sequencer holds only if its own result is ready first
// ----------------------------------------------------------------------------
module emission_rate_scheduler #(
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ers_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ers_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ers_in_if.sink                         in_i,
  ers_out_if.source                      out_o
);

  // command and status between sequencer and datapath
  ers_pkg::cmd_t    cmd;
  ers_pkg::status_t status;

  // sequencer: owns the request ready and the result valid
  ers_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: config, timers, rate multiply, shared divider, commit
  ers_datapath #(
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .time_step_i   (in_i.time_step),
    .live_count_i  (in_i.live_count),
    .rate_scale_i  (in_i.rate_scale),
    .cmd_i         (cmd),
    .status_o      (status),
    .spawn_count_o (out_o.spawn_count),
    .expired_o     (out_o.expired)
  );

endmodule

@@ design/ers_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ers_div
// restoring divider, one quotient bit per cycle, loadable partial remainder
// ----------------------------------------------------------------------------
module ers_div #(
  parameter int unsigned W = 48
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [W-1:0]               rem_init_i,
  input  logic [W-1:0]               num_i,
  input  logic [W-1:0]               divisor_i,
  input  logic [$clog2(W+1)-1:0]     steps_i,
  output logic                       busy_o,
  output logic [W-1:0]               quot_o,
  output logic [W-1:0]               rem_o
);

  localparam int unsigned SW = $clog2(W + 1);

  logic          busy_q, busy_d;
  logic [SW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  p_q, p_d;
  logic [W-1:0]  n_q, n_d;
  logic [W-1:0]  q_q, q_d;
  logic [W-1:0]  dv_q, dv_d;
  logic [W:0]    trial;
  logic [W:0]    diff;

  assign trial = {p_q, n_q[W-1]};
  assign diff  = trial - {1'b0, dv_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    p_d    = p_q;
    n_d    = n_q;
    q_d    = q_q;
    dv_d   = dv_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = steps_i;
      p_d    = rem_init_i;
      n_d    = num_i;
      q_d    = '0;
      dv_d   = divisor_i;
    end else if (busy_q) begin
      n_d = {n_q[W-2:0], 1'b0};
      if (trial >= {1'b0, dv_q}) begin
        p_d = diff[W-1:0];
        q_d = {q_q[W-2:0], 1'b1};
      end else begin
        p_d = trial[W-1:0];
        q_d = {q_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - SW'(1);
      if (cnt_q == SW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q  <= p_d;
    n_q  <= n_d;
    q_q  <= q_d;
    dv_q <= dv_d;
  end

  assign busy_o = busy_q;
  assign quot_o = q_q;
  assign rem_o  = p_q;

endmodule

@@ design/ers_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ers_datapath
// registers, rate multiply, period, request and modulo division, timer commit
// ----------------------------------------------------------------------------
module ers_datapath #(
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [ers_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ers_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // request payload
  input  logic [ers_pkg::TIME_W-1:0]        time_step_i,
  input  logic [ers_pkg::CNT_W-1:0]         live_count_i,
  input  logic [ers_pkg::SCALE_W-1:0]       rate_scale_i,
  // control
  input  ers_pkg::cmd_t                     cmd_i,
  output ers_pkg::status_t                  status_o,
  // result payload
  output logic [ers_pkg::CNT_W-1:0]         spawn_count_o,
  output logic                              expired_o
);

  localparam int unsigned T_W    = ers_pkg::T_W;
  localparam int unsigned CNT_W  = ers_pkg::CNT_W;
  localparam int unsigned R_W    = ers_pkg::R_W;
  localparam int unsigned D_W    = 2 * FRAC_BITS + 1;
  localparam int unsigned DIV_W  = (D_W > T_W) ? D_W : T_W;
  localparam int unsigned P_W    = D_W + CNT_W;
  localparam int unsigned CMP_W  = (P_W > T_W) ? P_W : T_W;
  localparam int unsigned WW     = COUNT_BITS + CNT_W;
  localparam int unsigned STEP_W = $clog2(DIV_W + 1);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] REQ_ONE = COUNT_BITS'(1);

  // configuration registers
  logic [ers_pkg::RATE_W-1:0] emit_rate_q;
  logic [ers_pkg::TIME_W-1:0] active_dur_q;
  logic [CNT_W-1:0]           burst_q;
  logic                       opf_q;
  logic [CNT_W-1:0]           max_q;

  // per-tick registers
  logic [ers_pkg::TIME_W-1:0]  step_q;
  logic [CNT_W-1:0]            live_q;
  logic [ers_pkg::SCALE_W-1:0] scale_q;
  logic [R_W-1:0]              r_q;
  logic [D_W-1:0]              d_q;
  logic [COUNT_BITS-1:0]       req_q;
  logic [CNT_W-1:0]            emitted_q;
  logic                        expired_q;
  logic [P_W-1:0]              prod_q;
  logic [P_W-1:0]              mcand_q;
  logic [CNT_W-1:0]            mer_q;

  // persistent state
  logic [T_W-1:0] elapsed_q;
  logic [T_W-1:0] timer_q;

  // result register
  logic [CNT_W-1:0] out_emit_q;
  logic             out_exp_q;

  // accumulate
  logic [T_W:0]   elapsed_sum;
  logic [T_W-1:0] elapsed_new;
  logic [T_W:0]   timer_sum;
  logic [T_W-1:0] timer_new;
  logic           expired_now;
  logic [ers_pkg::RATE_W+ers_pkg::SCALE_W-1:0] rate_prod;

  assign elapsed_sum = {1'b0, elapsed_q} + (T_W + 1)'(step_q);
  assign elapsed_new = elapsed_sum[T_W] ? '1 : elapsed_sum[T_W-1:0];
  assign timer_sum   = {1'b0, timer_q} + (T_W + 1)'(step_q);
  assign timer_new   = timer_sum[T_W] ? '1 : timer_sum[T_W-1:0];
  assign expired_now = (active_dur_q != '0) && (elapsed_new > T_W'(active_dur_q));
  assign rate_prod   = emit_rate_q * scale_q;

  // divider
  logic [DIV_W-1:0]  div_rem_init, div_num, div_divisor, div_quot, div_rem;
  logic [STEP_W-1:0] div_steps;
  logic              div_busy;

  always_comb begin
    case (cmd_i.div_sel)
      ers_pkg::DIV_RECIP: begin
        div_rem_init = '0;
        div_num      = {1'b1, {(DIV_W-1){1'b0}}};
        div_divisor  = DIV_W'(r_q);
        div_steps    = STEP_W'(D_W);
      end
      ers_pkg::DIV_QUOT: begin
        // partial remainder already below the period when the quotient fits
        div_rem_init = DIV_W'(timer_q >> COUNT_BITS);
        div_num      = {timer_q[COUNT_BITS-1:0], {(DIV_W-COUNT_BITS){1'b0}}};
        div_divisor  = DIV_W'(d_q);
        div_steps    = STEP_W'(COUNT_BITS);
      end
      ers_pkg::DIV_MOD: begin
        div_rem_init = '0;
        div_num      = DIV_W'(timer_q) << (DIV_W - T_W);
        div_divisor  = DIV_W'(d_q);
        div_steps    = STEP_W'(T_W);
      end
      default: begin
        div_rem_init = '0;
        div_num      = '0;
        div_divisor  = '0;
        div_steps    = '0;
      end
    endcase
  end

  ers_div #(
    .W (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .rem_init_i (div_rem_init),
    .num_i      (div_num),
    .divisor_i  (div_divisor),
    .steps_i    (div_steps),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // request selection
  logic                  rate_zero, d_zero, burst_hit, quot_sat;
  logic [WW-1:0]         burst_w;
  logic [COUNT_BITS-1:0] burst_req, rate_req, req_direct, req_div;

  function automatic logic [COUNT_BITS-1:0] cap_one(input logic [COUNT_BITS-1:0] v,
                                                    input logic opf);
    logic [COUNT_BITS-1:0] res;
    res = (opf && (v > REQ_ONE)) ? REQ_ONE : v;
    return res;
  endfunction

  assign rate_zero  = (r_q == '0);
  assign d_zero     = (d_q == '0);
  assign burst_hit  = (burst_q != '0) && (live_q == '0);
  assign quot_sat   = DIV_W'(timer_q >> COUNT_BITS) >= DIV_W'(d_q);
  assign burst_w    = WW'(burst_q);
  assign burst_req  = (burst_w > WW'(CNT_MAX)) ? CNT_MAX : burst_w[COUNT_BITS-1:0];
  assign rate_req   = rate_zero ? '0 : cap_one(CNT_MAX, opf_q);
  assign req_direct = burst_hit ? burst_req : rate_req;
  assign req_div    = cap_one(div_quot[COUNT_BITS-1:0], opf_q);

  // free slot clamp
  logic [CNT_W-1:0] room, emitted_d;
  logic             shortfall;

  assign room      = max_q - live_q;
  assign emitted_d = (live_q >= max_q) ? '0 :
                     ((WW'(req_q) < WW'(room)) ? CNT_W'(req_q) : room);
  assign shortfall = WW'(emitted_q) < WW'(req_q);

  // commit: timer less charged time, never below zero
  logic [CMP_W-1:0] prod_c, timer_c;
  logic [T_W-1:0]   rem_sub, rem_trim;

  assign prod_c   = CMP_W'(prod_q);
  assign timer_c  = CMP_W'(timer_q);
  assign rem_sub  = (prod_c > timer_c) ? '0 : T_W'(timer_c - prod_c);
  assign rem_trim = (shortfall && (DIV_W'(rem_sub) > DIV_W'(d_q))) ? T_W'(d_q) : rem_sub;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_rate_q  <= '0;
      active_dur_q <= '0;
      burst_q      <= '0;
      opf_q        <= 1'b0;
      max_q        <= ers_pkg::MAX_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ers_pkg::CFG_EMIT_RATE:       emit_rate_q  <= cfg_data_i[ers_pkg::RATE_W-1:0];
        ers_pkg::CFG_ACTIVE_DURATION: active_dur_q <= cfg_data_i[ers_pkg::TIME_W-1:0];
        ers_pkg::CFG_BURST_COUNT:     burst_q      <= cfg_data_i[CNT_W-1:0];
        ers_pkg::CFG_ONE_PER_FRAME:   opf_q        <= cfg_data_i[0];
        ers_pkg::CFG_MAX_COUNT:       max_q        <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      timer_q   <= '0;
    end else begin
      if (cmd_i.accum) begin
        elapsed_q <= elapsed_new;
        if (!expired_now) begin
          timer_q <= timer_new;
        end
      end
      if (cmd_i.timer_clear) begin
        timer_q <= '0;
      end
      if (cmd_i.trim_load) begin
        timer_q <= rem_trim;
      end
      if (cmd_i.mod_load) begin
        timer_q <= div_rem[T_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      step_q  <= time_step_i;
      live_q  <= live_count_i;
      scale_q <= rate_scale_i;
    end
    if (cmd_i.accum) begin
      r_q       <= R_W'(rate_prod >> ers_pkg::SCALE_SH);
      expired_q <= expired_now;
      emitted_q <= '0;
    end
    if (cmd_i.d_load) begin
      d_q <= div_quot[D_W-1:0];
    end
    if (cmd_i.req_load_direct) begin
      req_q <= req_direct;
    end
    if (cmd_i.req_load_div) begin
      req_q <= req_div;
    end
    if (cmd_i.emit_load) begin
      emitted_q <= emitted_d;
      mer_q     <= emitted_d;
      mcand_q   <= P_W'(d_q);
      prod_q    <= '0;
    end
    if (cmd_i.mul_step) begin
      if (mer_q[0]) begin
        prod_q <= prod_q + mcand_q;
      end
      mcand_q <= {mcand_q[P_W-2:0], 1'b0};
      mer_q   <= {1'b0, mer_q[CNT_W-1:1]};
    end
    if (cmd_i.out_load) begin
      out_emit_q <= emitted_q;
      out_exp_q  <= expired_q;
    end
  end

  always_comb begin
    status_o            = '0;
    status_o.expired    = expired_now;
    status_o.rate_zero  = rate_zero;
    status_o.req_direct = burst_hit || rate_zero || d_zero || quot_sat;
    status_o.div_busy   = div_busy;
    status_o.commit     = (req_q != '0) && !rate_zero;
    status_o.d_zero     = d_zero;
    status_o.mul_busy   = (mer_q != '0);
    status_o.mod_need   = opf_q && !shortfall;
  end

  assign spawn_count_o = out_emit_q;
  assign expired_o     = out_exp_q;

endmodule

@@ design/ers_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ers_ctrl
// sequencer for one frame tick and the result valid flag
// ----------------------------------------------------------------------------
module ers_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  ers_pkg::status_t status_i,
  output ers_pkg::cmd_t    cmd_o
);

  ers_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ers_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ers_pkg::ST_ACCUM;
        end
      end
      ers_pkg::ST_ACCUM: begin
        state_d = status_i.expired ? ers_pkg::ST_DONE : ers_pkg::ST_RECIP;
      end
      ers_pkg::ST_RECIP: begin
        state_d = status_i.rate_zero ? ers_pkg::ST_QUOT : ers_pkg::ST_RECIP_WAIT;
      end
      ers_pkg::ST_RECIP_WAIT: begin
        if (!status_i.div_busy) begin
          state_d = ers_pkg::ST_QUOT;
        end
      end
      ers_pkg::ST_QUOT: begin
        state_d = status_i.req_direct ? ers_pkg::ST_CLAMP : ers_pkg::ST_QUOT_WAIT;
      end
      ers_pkg::ST_QUOT_WAIT: begin
        if (!status_i.div_busy) begin
          state_d = ers_pkg::ST_CLAMP;
        end
      end
      ers_pkg::ST_CLAMP: begin
        if (!status_i.commit || status_i.d_zero) begin
          state_d = ers_pkg::ST_DONE;
        end else begin
          state_d = ers_pkg::ST_MULT;
        end
      end
      ers_pkg::ST_MULT: begin
        if (!status_i.mul_busy) begin
          state_d = ers_pkg::ST_TRIM;
        end
      end
      ers_pkg::ST_TRIM: begin
        state_d = status_i.mod_need ? ers_pkg::ST_MOD : ers_pkg::ST_DONE;
      end
      ers_pkg::ST_MOD: begin
        state_d = ers_pkg::ST_MOD_WAIT;
      end
      ers_pkg::ST_MOD_WAIT: begin
        if (!status_i.div_busy) begin
          state_d = ers_pkg::ST_DONE;
        end
      end
      ers_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = ers_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ers_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.div_sel = ers_pkg::DIV_RECIP;
    in_ready_o    = 1'b0;
    case (state_q)
      ers_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ers_pkg::ST_ACCUM: begin
        cmd_o.accum = 1'b1;
      end
      ers_pkg::ST_RECIP: begin
        cmd_o.div_start = !status_i.rate_zero;
        cmd_o.div_sel   = ers_pkg::DIV_RECIP;
      end
      ers_pkg::ST_RECIP_WAIT: begin
        cmd_o.div_sel = ers_pkg::DIV_RECIP;
        cmd_o.d_load  = !status_i.div_busy;
      end
      ers_pkg::ST_QUOT: begin
        cmd_o.div_sel         = ers_pkg::DIV_QUOT;
        cmd_o.req_load_direct = status_i.req_direct;
        cmd_o.div_start       = !status_i.req_direct;
      end
      ers_pkg::ST_QUOT_WAIT: begin
        cmd_o.div_sel      = ers_pkg::DIV_QUOT;
        cmd_o.req_load_div = !status_i.div_busy;
      end
      ers_pkg::ST_CLAMP: begin
        cmd_o.emit_load   = 1'b1;
        cmd_o.timer_clear = status_i.commit && status_i.d_zero;
      end
      ers_pkg::ST_MULT: begin
        cmd_o.mul_step = status_i.mul_busy;
      end
      ers_pkg::ST_TRIM: begin
        cmd_o.trim_load = 1'b1;
      end
      ers_pkg::ST_MOD: begin
        cmd_o.div_sel   = ers_pkg::DIV_MOD;
        cmd_o.div_start = 1'b1;
      end
      ers_pkg::ST_MOD_WAIT: begin
        cmd_o.div_sel  = ers_pkg::DIV_MOD;
        cmd_o.mod_load = !status_i.div_busy;
      end
      ers_pkg::ST_DONE: begin
        cmd_o.out_load = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ers_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
